/* src/assert_macros.svh */
// Assertion macros for the checker file of the tracker.
// Expects clk and rst_n to be visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AHDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AHDT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ahdt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the access hazard dependency tracker.
// No dependencies; imported by the controller, datapath and top level.
package ahdt_pkg;

    localparam int RES_ID_W   = 8;
    localparam int RES_SPAN   = 2 ** RES_ID_W;
    localparam int USE_W      = 2;
    localparam int NODE_OUT_W = 16;
    localparam int BASE_W     = 32;
    localparam int COUNT_W    = 5;

    localparam logic [USE_W-1:0] USE_NONE  = 2'd0;
    localparam logic [USE_W-1:0] USE_READ  = 2'd1;
    localparam logic [USE_W-1:0] USE_WRITE = 2'd2;
    localparam logic [USE_W-1:0] USE_RW    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_REPLAY
    } ctl_state_t;

    typedef struct packed {
        logic accept;   // capture input word, start table reads
        logic lookup;   // resolve dependency, load result register
        logic rp_step;  // one replay step of buffered table updates
        logic close;    // finish node: advance counter, clear buffers
    } ahdt_cmd_t;

    typedef struct packed {
        logic item_end;
        logic rp_done;
    } ahdt_stat_t;

endpackage

/* src/ahdt_ctrl.sv */
`timescale 1ns / 1ps
// Control FSM of the tracker: handshakes and sequencing of the datapath.
// Depends on ahdt_pkg.
module ahdt_ctrl
    import ahdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ahdt_stat_t stat,
    output ahdt_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       load_ok;

    // result register is free, or its word leaves this cycle
    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (load_ok)
                    state_next = stat.item_end ? ST_REPLAY : ST_IDLE;
            end
            ST_REPLAY:
            begin
                if (stat.rp_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
                cmd.lookup = load_ok;
            ST_REPLAY:
            begin
                cmd.rp_step = 1'b1;
                cmd.close   = stat.rp_done;
            end
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.lookup)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/ahdt_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the tracker: last-accessor/last-writer tables, node buffers,
// dedup compare and result register. Depends on ahdt_pkg.
module ahdt_datapath
    import ahdt_pkg::*;
#(
    parameter int NUM_RESOURCES         = 256,
    parameter int MAX_ACCESSES_PER_NODE = 16,
    parameter int NODE_ID_BITS          = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ahdt_cmd_t             cmd,
    output ahdt_stat_t            stat,
    input  logic                  start_graph,
    input  logic [RES_ID_W-1:0]   resource_id,
    input  logic [USE_W-1:0]      usage,
    input  logic                  node_end,
    output logic                  dep_found,
    output logic [NODE_OUT_W-1:0] dep_on_node,
    output logic [NODE_OUT_W-1:0] this_node,
    output logic                  node_done,
    output logic [BASE_W-1:0]     dep_base,
    output logic [COUNT_W-1:0]    deps_in_node,
    output logic                  overflow
);

    localparam int TBL_DEPTH = (NUM_RESOURCES < RES_SPAN) ? NUM_RESOURCES : RES_SPAN;
    localparam int IDX_W     = $clog2(TBL_DEPTH);
    localparam int FILL_W    = $clog2(MAX_ACCESSES_PER_NODE + 1);
    localparam int PIDX_W    = (MAX_ACCESSES_PER_NODE > 1) ? $clog2(MAX_ACCESSES_PER_NODE) : 1;
    localparam int PEND_W    = IDX_W + USE_W;
    localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_ACCESSES_PER_NODE);

    // table memories, no reset; valid bits below qualify every read
    logic [NODE_ID_BITS-1:0] la_mem [TBL_DEPTH];
    logic [NODE_ID_BITS-1:0] lw_mem [TBL_DEPTH];
    logic [PEND_W-1:0]       pend_mem [MAX_ACCESSES_PER_NODE];
    logic [NODE_ID_BITS-1:0] found_reg [MAX_ACCESSES_PER_NODE];

    logic [TBL_DEPTH-1:0]    lav_reg;
    logic [TBL_DEPTH-1:0]    lwv_reg;
    logic [NODE_ID_BITS-1:0] la_rd_reg;
    logic [NODE_ID_BITS-1:0] lw_rd_reg;
    logic [PEND_W-1:0]       pend_rd_reg;

    logic [IDX_W-1:0]        item_idx_reg;
    logic [USE_W-1:0]        item_use_reg;
    logic                    item_end_reg;

    logic [NODE_ID_BITS-1:0] node_counter_reg;
    logic [BASE_W-1:0]       dep_total_reg;
    logic [FILL_W-1:0]       node_fill_reg;
    logic [FILL_W-1:0]       found_fill_reg;
    logic                    node_over_reg;
    logic [FILL_W-1:0]       rp_idx_reg;
    logic                    rp_vld_reg;

    logic                    dep_found_reg;
    logic [NODE_OUT_W-1:0]   dep_on_node_reg;
    logic [NODE_OUT_W-1:0]   this_node_reg;
    logic                    node_done_reg;
    logic [BASE_W-1:0]       dep_base_reg;
    logic [COUNT_W-1:0]      deps_in_node_reg;
    logic                    overflow_reg;

    logic                    in_range;
    logic [USE_W-1:0]        in_use_eff;
    logic                    use_real;
    logic                    buf_full;
    logic                    store;
    logic                    dropped;
    logic                    is_wr;
    logic                    have;
    logic [NODE_ID_BITS-1:0] cand;
    logic                    seen;
    logic                    add;
    logic [FILL_W-1:0]       found_fill_new;
    logic                    over_new;
    logic                    rp_more;
    logic [IDX_W-1:0]        rp_res;
    logic [USE_W-1:0]        rp_use;

    // ids at or above the table depth act as usage none
    assign in_range   = (32'(resource_id) < NUM_RESOURCES);
    assign in_use_eff = in_range ? usage : USE_NONE;

    assign use_real = (item_use_reg != USE_NONE);
    assign buf_full = (node_fill_reg >= MAX_FILL);
    assign store    = use_real && !buf_full;
    assign dropped  = use_real && buf_full;
    assign is_wr    = (item_use_reg == USE_WRITE) || (item_use_reg == USE_RW);
    assign have     = is_wr ? lav_reg[item_idx_reg] : lwv_reg[item_idx_reg];
    assign cand     = is_wr ? la_rd_reg : lw_rd_reg;

    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < MAX_ACCESSES_PER_NODE; i++)
        begin
            if ((FILL_W'(i) < found_fill_reg) && (found_reg[i] == cand))
                seen = 1'b1;
        end
    end

    assign add            = store && have && !seen && (found_fill_reg < MAX_FILL);
    assign found_fill_new = found_fill_reg + FILL_W'(add);
    assign over_new       = node_over_reg || dropped;

    assign rp_more = (rp_idx_reg < node_fill_reg);
    assign rp_res  = pend_rd_reg[PEND_W-1:USE_W];
    assign rp_use  = pend_rd_reg[USE_W-1:0];

    assign stat.item_end = item_end_reg;
    assign stat.rp_done  = !rp_more && !rp_vld_reg;

    // memories: table reads at accept, replay writes, buffer fill and drain
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            la_rd_reg <= la_mem[resource_id[IDX_W-1:0]];
            lw_rd_reg <= lw_mem[resource_id[IDX_W-1:0]];
        end
        if (cmd.rp_step && rp_vld_reg)
        begin
            la_mem[rp_res] <= node_counter_reg;
            if (rp_use != USE_READ)
                lw_mem[rp_res] <= node_counter_reg;
        end
        if (cmd.lookup && store)
            pend_mem[node_fill_reg[PIDX_W-1:0]] <= {item_idx_reg, item_use_reg};
        if (cmd.rp_step && rp_more)
            pend_rd_reg <= pend_mem[rp_idx_reg[PIDX_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_idx_reg <= resource_id[IDX_W-1:0];
            item_use_reg <= in_use_eff;
            item_end_reg <= node_end;
        end
        if (cmd.lookup)
        begin
            if (add)
                found_reg[found_fill_reg[PIDX_W-1:0]] <= cand;
            dep_found_reg    <= add;
            dep_on_node_reg  <= add ? NODE_OUT_W'(cand) : '0;
            this_node_reg    <= NODE_OUT_W'(node_counter_reg);
            node_done_reg    <= item_end_reg;
            dep_base_reg     <= item_end_reg ? dep_total_reg : '0;
            deps_in_node_reg <= item_end_reg ? COUNT_W'(found_fill_new) : '0;
            overflow_reg     <= item_end_reg ? over_new : dropped;
        end
    end

    // control state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lav_reg          <= '0;
            lwv_reg          <= '0;
            node_counter_reg <= '0;
            dep_total_reg    <= '0;
            node_fill_reg    <= '0;
            found_fill_reg   <= '0;
            node_over_reg    <= 1'b0;
            rp_idx_reg       <= '0;
            rp_vld_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.accept && start_graph)
            begin
                lav_reg          <= '0;
                lwv_reg          <= '0;
                node_counter_reg <= '0;
                dep_total_reg    <= '0;
                node_fill_reg    <= '0;
                found_fill_reg   <= '0;
                node_over_reg    <= 1'b0;
                rp_idx_reg       <= '0;
                rp_vld_reg       <= 1'b0;
            end
            if (cmd.lookup)
            begin
                node_fill_reg  <= node_fill_reg + FILL_W'(store);
                found_fill_reg <= found_fill_new;
                node_over_reg  <= over_new;
                if (item_end_reg)
                    dep_total_reg <= dep_total_reg + BASE_W'(found_fill_new);
            end
            if (cmd.rp_step)
            begin
                rp_vld_reg <= rp_more;
                if (rp_more)
                    rp_idx_reg <= rp_idx_reg + FILL_W'(1);
                if (rp_vld_reg)
                begin
                    lav_reg[rp_res] <= 1'b1;
                    if (rp_use != USE_READ)
                        lwv_reg[rp_res] <= 1'b1;
                end
            end
            if (cmd.close)
            begin
                node_counter_reg <= node_counter_reg + NODE_ID_BITS'(1);
                node_fill_reg    <= '0;
                found_fill_reg   <= '0;
                node_over_reg    <= 1'b0;
                rp_idx_reg       <= '0;
                rp_vld_reg       <= 1'b0;
            end
        end
    end

    assign dep_found    = dep_found_reg;
    assign dep_on_node  = dep_on_node_reg;
    assign this_node    = this_node_reg;
    assign node_done    = node_done_reg;
    assign dep_base     = dep_base_reg;
    assign deps_in_node = deps_in_node_reg;
    assign overflow     = overflow_reg;

endmodule

/* src/access_hazard_dependency_tracker_core.sv */
`timescale 1ns / 1ps
// Access hazard dependency tracker, top level: ahdt_ctrl + ahdt_datapath, uses ahdt_pkg.
// Each access passes idle and lookup: the word is registered at accept, and the lookup
// then loads the result register. A held result word stalls the next lookup, and no new
// access is taken during lookup. A node's last access then replays its k buffered accesses.
// Reset (async, rst_n low) clears control, valid bits and counters; no clearing pass.
module access_hazard_dependency_tracker_core
    import ahdt_pkg::*;
#(
    parameter int NUM_RESOURCES         = 256,
    parameter int MAX_ACCESSES_PER_NODE = 16,
    parameter int NODE_ID_BITS          = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_graph,
    input  logic [RES_ID_W-1:0]   resource_id,
    input  logic [USE_W-1:0]      usage,
    input  logic                  node_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dep_found,
    output logic [NODE_OUT_W-1:0] dep_on_node,
    output logic [NODE_OUT_W-1:0] this_node,
    output logic                  node_done,
    output logic [BASE_W-1:0]     dep_base,
    output logic [COUNT_W-1:0]    deps_in_node,
    output logic                  overflow
);

    ahdt_cmd_t  cmd;
    ahdt_stat_t stat;

    ahdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ahdt_datapath #(
        .NUM_RESOURCES         (NUM_RESOURCES),
        .MAX_ACCESSES_PER_NODE (MAX_ACCESSES_PER_NODE),
        .NODE_ID_BITS          (NODE_ID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .start_graph  (start_graph),
        .resource_id  (resource_id),
        .usage        (usage),
        .node_end     (node_end),
        .dep_found    (dep_found),
        .dep_on_node  (dep_on_node),
        .this_node    (this_node),
        .node_done    (node_done),
        .dep_base     (dep_base),
        .deps_in_node (deps_in_node),
        .overflow     (overflow)
    );

endmodule

/* src/ahdt_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the tracker top level, bound in below.
// Depends on ahdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ahdt_checker
    import ahdt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  start_graph,
    input logic [RES_ID_W-1:0]   resource_id,
    input logic [USE_W-1:0]      usage,
    input logic                  node_end,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  dep_found,
    input logic [NODE_OUT_W-1:0] dep_on_node,
    input logic [NODE_OUT_W-1:0] this_node,
    input logic                  node_done,
    input logic [BASE_W-1:0]     dep_base,
    input logic [COUNT_W-1:0]    deps_in_node,
    input logic                  overflow
);

    // one word in flight: no second accept right behind the first
    `AHDT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted back to back")

    // waiting input word holds
    `AHDT_ASSERT_NXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(start_graph) && $stable(resource_id) && $stable(usage)
        && $stable(node_end), "waiting input word changed")

    // stalled result word holds
    `AHDT_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(dep_found) && $stable(dep_on_node) && $stable(this_node)
        && $stable(node_done) && $stable(dep_base) && $stable(deps_in_node)
        && $stable(overflow), "stalled result changed")

    `AHDT_ASSERT_IMP(a_no_dep_zero, out_valid && !dep_found, dep_on_node == '0,
        "dep_on_node set without dependency")

    `AHDT_ASSERT_IMP(a_mid_node_zero, out_valid && !node_done,
        (dep_base == '0) && (deps_in_node == '0), "node totals outside node end")

endmodule

bind access_hazard_dependency_tracker_core ahdt_checker u_ahdt_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for access_hazard_dependency_tracker_core; needs ahdt_pkg and the core.
// A local scoreboard of last accessor / last writer tables predicts every result word.
module testbench;
    import ahdt_pkg::*;

    localparam int MAX_ACC     = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                  found;
        logic [NODE_OUT_W-1:0] dep;
        logic [NODE_OUT_W-1:0] node;
        logic                  done;
        logic [BASE_W-1:0]     base;
        logic [COUNT_W-1:0]    cnt;
        logic                  ovf;
    } dep_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  start_graph = 1'b0;
    logic [RES_ID_W-1:0]   resource_id = '0;
    logic [USE_W-1:0]      usage = USE_NONE;
    logic                  node_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  dep_found;
    logic [NODE_OUT_W-1:0] dep_on_node;
    logic [NODE_OUT_W-1:0] this_node;
    logic                  node_done;
    logic [BASE_W-1:0]     dep_base;
    logic [COUNT_W-1:0]    deps_in_node;
    logic                  overflow;

    // scoreboard state
    logic [NODE_OUT_W-1:0] accessor_tab [RES_SPAN];
    bit                    accessor_ok  [RES_SPAN];
    logic [NODE_OUT_W-1:0] writer_tab   [RES_SPAN];
    bit                    writer_ok    [RES_SPAN];
    logic [NODE_OUT_W-1:0] node_cnt;
    logic [BASE_W-1:0]     dep_sum;
    logic [RES_ID_W+USE_W-1:0] node_accesses [MAX_ACC];
    logic [NODE_OUT_W-1:0] node_deps [MAX_ACC];
    int                    access_fill;
    int                    dep_fill;
    bit                    node_ovf;

    dep_result_t due_results [$];
    dep_result_t front_result;
    int          errors = 0;
    int          cycle_count = 0;
    int          in_idle_pct = 32;
    int          out_idle_pct = 32;

    access_hazard_dependency_tracker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_graph  (start_graph),
        .resource_id  (resource_id),
        .usage        (usage),
        .node_end     (node_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dep_found    (dep_found),
        .dep_on_node  (dep_on_node),
        .this_node    (this_node),
        .node_done    (node_done),
        .dep_base     (dep_base),
        .deps_in_node (deps_in_node),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic void clear_tables();
        foreach (accessor_ok[i])
        begin
            accessor_ok[i] = 1'b0;
            writer_ok[i] = 1'b0;
        end
        node_cnt = '0;
        dep_sum = '0;
        access_fill = 0;
        dep_fill = 0;
        node_ovf = 1'b0;
    endfunction

    function automatic dep_result_t predict_hazard(logic sg, logic [RES_ID_W-1:0] rid,
                                                   logic [USE_W-1:0] acc_use, logic ne);
        dep_result_t r;
        logic [NODE_OUT_W-1:0] cand;
        bit have;
        bit seen;
        logic [RES_ID_W-1:0] pr;
        r = '0;
        if (sg)
            clear_tables();
        if (acc_use != USE_NONE)
        begin
            if (access_fill >= MAX_ACC)
            begin
                r.ovf = 1'b1;
                node_ovf = 1'b1;
            end
            else
            begin
                node_accesses[access_fill] = {rid, acc_use};
                access_fill++;
                have = 1'b0;
                cand = '0;
                if (acc_use == USE_WRITE || acc_use == USE_RW)
                begin
                    if (accessor_ok[rid])
                    begin
                        have = 1'b1;
                        cand = accessor_tab[rid];
                    end
                end
                else if (writer_ok[rid])
                begin
                    have = 1'b1;
                    cand = writer_tab[rid];
                end
                if (have)
                begin
                    seen = 1'b0;
                    for (int i = 0; i < dep_fill; i++)
                        if (node_deps[i] == cand)
                            seen = 1'b1;
                    if (!seen && dep_fill < MAX_ACC)
                    begin
                        node_deps[dep_fill] = cand;
                        dep_fill++;
                        r.found = 1'b1;
                        r.dep = cand;
                    end
                end
            end
        end
        r.node = node_cnt;
        r.done = ne;
        if (ne)
        begin
            // buffered table updates land in access order
            for (int i = 0; i < access_fill; i++)
            begin
                pr = node_accesses[i][RES_ID_W+USE_W-1:USE_W];
                accessor_tab[pr] = node_cnt;
                accessor_ok[pr] = 1'b1;
                if (node_accesses[i][USE_W-1:0] == USE_WRITE ||
                    node_accesses[i][USE_W-1:0] == USE_RW)
                begin
                    writer_tab[pr] = node_cnt;
                    writer_ok[pr] = 1'b1;
                end
            end
            r.base = dep_sum;
            r.cnt = dep_fill[COUNT_W-1:0];
            r.ovf = node_ovf;
            dep_sum = dep_sum + BASE_W'(dep_fill);
            node_cnt = node_cnt + NODE_OUT_W'(1);
            access_fill = 0;
            dep_fill = 0;
            node_ovf = 1'b0;
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    // in_valid stays high afterwards, so callers that do not send at once lower it.
    task automatic push_access(input logic sg, input logic [RES_ID_W-1:0] rid,
                               input logic [USE_W-1:0] acc_use, input logic ne);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        start_graph <= sg;
        resource_id <= rid;
        usage <= acc_use;
        node_end <= ne;
        do
            @(posedge clk);
        while (!in_ready);
        due_results.push_back(predict_hazard(sg, rid, acc_use, ne));
    endtask

    // always moves past at least one edge, so the next driver starts in a later step
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic check_field(input string what, input logic [BASE_W-1:0] want,
                               input logic [BASE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none actual node %0h",
                         $time, this_node);
                errors++;
            end
            else
            begin
                front_result = due_results.pop_front();
                check_field("dep_found", BASE_W'(front_result.found), BASE_W'(dep_found));
                check_field("dep_on_node", BASE_W'(front_result.dep), BASE_W'(dep_on_node));
                check_field("this_node", BASE_W'(front_result.node), BASE_W'(this_node));
                check_field("node_done", BASE_W'(front_result.done), BASE_W'(node_done));
                check_field("dep_base", front_result.base, dep_base);
                check_field("deps_in_node", BASE_W'(front_result.cnt), BASE_W'(deps_in_node));
                check_field("overflow", BASE_W'(front_result.ovf), BASE_W'(overflow));
            end
        end
    end

    // reads after writers, writes after accessors, dedup, start_graph mid-node
    task automatic test_directed_hazards();
        push_access(1'b1, 8'd0, USE_WRITE, 1'b1);
        push_access(1'b0, 8'd255, USE_RW, 1'b1);
        push_access(1'b0, 8'd0, USE_READ, 1'b0);
        push_access(1'b0, 8'd0, USE_READ, 1'b0);
        push_access(1'b0, 8'd255, USE_READ, 1'b0);
        push_access(1'b0, 8'd0, USE_WRITE, 1'b0);
        push_access(1'b0, 8'd128, USE_NONE, 1'b1);
        push_access(1'b0, 8'd0, USE_WRITE, 1'b1);
        push_access(1'b0, 8'd255, USE_WRITE, 1'b0);
        push_access(1'b0, 8'd85, USE_NONE, 1'b0);
        push_access(1'b0, 8'd170, USE_READ, 1'b0);
        push_access(1'b1, 8'd0, USE_READ, 1'b0);
        push_access(1'b0, 8'd0, USE_RW, 1'b1);
        push_access(1'b0, 8'd0, USE_NONE, 1'b1);
        push_access(1'b0, 8'd0, USE_READ, 1'b1);
        push_access(1'b0, 8'd0, USE_RW, 1'b0);
        push_access(1'b0, 8'd0, USE_WRITE, 1'b1);
        drain_results();
    endtask

    // 16 distinct deps in one node, then accesses past the buffer are dropped
    task automatic test_buffer_overflow();
        for (int i = 0; i <= MAX_ACC; i++)
            push_access(i == 0, i[RES_ID_W-1:0], USE_WRITE, 1'b1);
        for (int i = 0; i < MAX_ACC; i++)
            push_access(1'b0, i[RES_ID_W-1:0], USE_READ, 1'b0);
        push_access(1'b0, 8'd16, USE_WRITE, 1'b0);
        push_access(1'b0, 8'd200, USE_NONE, 1'b0);
        push_access(1'b0, 8'd17, USE_READ, 1'b1);
        push_access(1'b0, 8'd3, USE_WRITE, 1'b1);
        drain_results();
    endtask

    // mostly well-formed nodes over a small resource pool, with stray graph restarts
    task automatic test_random_nodes();
        int sent;
        int roll;
        int n_acc;
        logic [RES_ID_W-1:0] rid;
        logic sg;
        sent = 0;
        while (sent < 1150)
        begin
            if (sent >= 400 && sent < 650)
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct = 32;
                out_idle_pct = 32;
            end
            roll = $urandom_range(99);
            if (roll < 85)
                n_acc = $urandom_range(6, 1);
            else if (roll < 95)
                n_acc = $urandom_range(16, 7);
            else
                n_acc = $urandom_range(22, 17);
            for (int k = 0; k < n_acc; k++)
            begin
                if ($urandom_range(99) < 80)
                    rid = RES_ID_W'($urandom_range(15));
                else
                    rid = RES_ID_W'($urandom_range(255));
                if (k == 0)
                    sg = ($urandom_range(49) == 0);
                else
                    sg = ($urandom_range(199) == 0);
                push_access(sg, rid, USE_W'($urandom_range(3)), k == n_acc - 1);
                sent++;
            end
            if ($urandom_range(39) == 0)
                drain_results();
        end
        in_idle_pct = 32;
        out_idle_pct = 32;
        drain_results();
    endtask

    initial
    begin
        clear_tables();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_hazards();
        test_buffer_overflow();
        test_random_nodes();
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* access_hazard_dependency_tracker_core.f */
+incdir+src
src/ahdt_pkg.sv
src/ahdt_ctrl.sv
src/ahdt_datapath.sv
src/access_hazard_dependency_tracker_core.sv
src/ahdt_checker.sv
test/testbench.sv
